@@ rtl/core/ordered_list_table_unit_assert.svh @@
// assertion macros for the ordered list table unit
// no dependencies; included by the top level only
`ifndef ORDERED_LIST_TABLE_UNIT_ASSERT_SVH
`define ORDERED_LIST_TABLE_UNIT_ASSERT_SVH

// property holds at every edge outside reset
`define OLT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define OLT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/olt_pkg.sv @@
// shared types and constants for the ordered list table unit
// no dependencies
`default_nettype none

package olt_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;

    localparam logic [DATA_W-1:0] FAIL_WORD = '1;

    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_GET    = 3'd3,
        KIND_LOCATE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } t_cell_op;

    typedef enum logic [1:0] {
        SRCH_NONE,
        SRCH_MATCH,
        SRCH_INDEX
    } t_search;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op          op;
        t_search           search;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

    // search word handed from cell to cell
    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } t_carry;

endpackage

`default_nettype wire

@@ rtl/core/olt_cell.sv @@
// one list cell: holds one entry, shifts with its neighbors, passes the search word on
// depends on olt_pkg
`default_nettype none

module olt_cell #(
    parameter int MAX_ENTRIES = 16,
    parameter int INDEX       = 0,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                              i_clk,
    input  olt_pkg::t_cell_cmd                i_cmd,
    input  logic [IDX_W-1:0]                  i_target,
    input  logic [CNT_W-1:0]                  i_count,
    input  logic [olt_pkg::DATA_W-1:0]        i_left_entry,
    input  logic [olt_pkg::DATA_W-1:0]        i_right_entry,
    input  olt_pkg::t_carry                   i_carry,
    output logic [olt_pkg::DATA_W-1:0]        o_entry,
    output olt_pkg::t_carry                   o_carry
);

    localparam logic [IDX_W-1:0]          MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0]          MY_CNT = CNT_W'(INDEX);
    localparam logic [olt_pkg::POS_W-1:0] MY_POS = olt_pkg::POS_W'(INDEX + 1);

    logic [olt_pkg::DATA_W-1:0] r_entry;
    logic [olt_pkg::DATA_W-1:0] n_entry;
    olt_pkg::t_carry            r_carry;
    olt_pkg::t_carry            n_carry;
    logic                       w_hit;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            olt_pkg::OP_INSERT: begin
                if (MY_IDX == i_target) begin
                    n_entry = i_cmd.value;
                end else if (MY_IDX > i_target) begin
                    n_entry = i_left_entry;
                end
            end
            olt_pkg::OP_DELETE: begin
                if (MY_IDX >= i_target) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.search)
            olt_pkg::SRCH_MATCH: w_hit = (r_entry == i_cmd.value) && (MY_CNT < i_count);
            olt_pkg::SRCH_INDEX: w_hit = (MY_IDX == i_target);
            default:             w_hit = 1'b0;
        endcase

        // first hit along the chain wins
        n_carry = i_carry;
        if (!i_carry.hit && w_hit) begin
            n_carry.hit  = 1'b1;
            n_carry.pos  = MY_POS;
            n_carry.data = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_carry <= n_carry;
    end

    assign o_entry = r_entry;
    assign o_carry = r_carry;

endmodule

`default_nettype wire

@@ rtl/core/olt_ctrl.sv @@
// request sequencer: takes a word, walks the search along the cells, applies the shift
// depends on olt_pkg
`default_nettype none

module olt_ctrl #(
    parameter int MAX_ENTRIES = 16,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_kind,
    input  logic [olt_pkg::POS_W-1:0]         i_position,
    input  logic [olt_pkg::DATA_W-1:0]        i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_ok,
    output logic [olt_pkg::DATA_W-1:0]        o_data_out,
    output logic [olt_pkg::POS_W-1:0]         o_found_position,
    output logic [olt_pkg::POS_W-1:0]         o_entry_count,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output olt_pkg::t_cell_cmd                o_cmd,
    output logic [IDX_W-1:0]                  o_target,
    output logic [CNT_W-1:0]                  o_count,
    input  olt_pkg::t_carry                   i_carry
);

    localparam int EXT_W = (CNT_W > olt_pkg::POS_W) ? CNT_W : olt_pkg::POS_W;
    localparam int SWP_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ENTRIES);
    localparam logic [SWP_W-1:0] SWP_START = SWP_W'(MAX_ENTRIES - 1);

    olt_pkg::t_state            r_state;
    olt_pkg::t_state            n_state;
    logic [SWP_W-1:0]           r_sweep;
    logic [SWP_W-1:0]           n_sweep;
    logic [2:0]                 r_kind;
    logic [olt_pkg::POS_W-1:0]  r_pos;
    logic [olt_pkg::DATA_W-1:0] r_value;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_ok;
    logic [olt_pkg::DATA_W-1:0] r_data;
    logic [olt_pkg::POS_W-1:0]  r_found;

    logic [EXT_W-1:0]           w_pos_x;
    logic [EXT_W-1:0]           w_cnt_x;
    logic                       w_full;
    logic                       w_pos_valid;
    logic                       w_ins_pos_valid;
    logic [IDX_W-1:0]           w_pos_idx;
    logic [IDX_W-1:0]           w_cnt_idx;
    logic                       w_accept;
    logic                       w_load;

    // decoded request
    logic                       w_res_ok;
    logic [olt_pkg::DATA_W-1:0] w_res_data;
    logic [olt_pkg::POS_W-1:0]  w_res_found;
    olt_pkg::t_cell_op          w_op;
    olt_pkg::t_search           w_search;
    logic [IDX_W-1:0]           w_tgt;
    logic [CNT_W-1:0]           w_cnt_next;

    assign w_pos_x         = EXT_W'(r_pos);
    assign w_cnt_x         = EXT_W'(r_count);
    assign w_full          = (r_count == FULL_CNT);
    assign w_pos_valid     = (r_pos != '0) && (w_pos_x <= w_cnt_x);
    assign w_ins_pos_valid = (r_pos != '0) && (w_pos_x <= (w_cnt_x + EXT_W'(1)));
    assign w_pos_idx       = IDX_W'(w_pos_x - EXT_W'(1));
    assign w_cnt_idx       = IDX_W'(w_cnt_x);

    always_comb begin
        w_res_ok    = 1'b0;
        w_res_data  = '0;
        w_res_found = '0;
        w_op        = olt_pkg::OP_HOLD;
        w_search    = olt_pkg::SRCH_NONE;
        w_tgt       = w_pos_idx;
        w_cnt_next  = r_count;
        unique case (olt_pkg::t_kind'(r_kind))
            olt_pkg::KIND_APPEND: begin
                // append is an insert just past the tail
                w_res_ok   = !w_full;
                w_op       = olt_pkg::OP_INSERT;
                w_tgt      = w_cnt_idx;
                w_cnt_next = r_count + CNT_W'(1);
            end
            olt_pkg::KIND_INSERT: begin
                w_res_ok   = !w_full && w_ins_pos_valid;
                w_op       = olt_pkg::OP_INSERT;
                w_cnt_next = r_count + CNT_W'(1);
            end
            olt_pkg::KIND_DELETE: begin
                w_res_ok   = w_pos_valid;
                w_search   = olt_pkg::SRCH_INDEX;
                w_res_data = w_pos_valid ? i_carry.data : '0;
                w_op       = olt_pkg::OP_DELETE;
                w_cnt_next = r_count - CNT_W'(1);
            end
            olt_pkg::KIND_GET: begin
                w_res_ok   = w_pos_valid;
                w_search   = olt_pkg::SRCH_INDEX;
                w_res_data = w_pos_valid ? i_carry.data : olt_pkg::FAIL_WORD;
            end
            olt_pkg::KIND_LOCATE: begin
                w_search    = olt_pkg::SRCH_MATCH;
                w_res_ok    = i_carry.hit;
                w_res_found = i_carry.hit ? i_carry.pos : '0;
            end
            default: begin
                w_res_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_stall;
        w_load       = 1'b0;
        o_stall      = (r_state != olt_pkg::ST_IDLE);
        o_cmd.op     = olt_pkg::OP_HOLD;
        o_cmd.search = olt_pkg::SRCH_NONE;
        o_cmd.value  = r_value;
        unique case (r_state)
            olt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = olt_pkg::ST_SWEEP;
                    n_sweep = SWP_START;
                end
            end
            olt_pkg::ST_SWEEP: begin
                o_cmd.search = w_search;
                if (r_sweep == '0) begin
                    n_state = olt_pkg::ST_FINISH;
                end else begin
                    n_sweep = r_sweep - SWP_W'(1);
                end
            end
            olt_pkg::ST_FINISH: begin
                // search word must keep flowing until the result is taken
                o_cmd.search = w_search;
                if (!r_out_valid || !i_stall) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = olt_pkg::ST_IDLE;
                    if (w_res_ok) begin
                        o_cmd.op = w_op;
                        n_count  = w_cnt_next;
                    end
                end
            end
            default: begin
                n_state = olt_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olt_pkg::ST_IDLE;
            r_sweep     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        if (w_load) begin
            r_ok    <= w_res_ok;
            r_data  <= w_res_data;
            r_found <= w_res_found;
        end
    end

    // count only moves when a result is loaded, so it tracks the word on the output
    assign o_valid          = r_out_valid;
    assign o_ok             = r_ok;
    assign o_data_out       = r_data;
    assign o_found_position = r_found;
    assign o_entry_count    = w_cnt_x[olt_pkg::POS_W-1:0];
    assign o_is_empty       = (r_count == '0);
    assign o_is_full        = w_full;
    assign o_target         = w_tgt;
    assign o_count          = r_count;

endmodule

`default_nettype wire

@@ rtl/core/ordered_list_table_unit.sv @@
// Ordered list of up to MAX_ENTRIES signed 32-bit words held in a row of cells, one entry
// per cell, with append, insert-at, delete-at, get-at and locate requests. After accepting
// a word, the block takes no new one until it is done with it: the search word that finds
// the addressed entry or the first match walks the cell chain one cell per clock, then a
// finish step applies the shift to all cells at once and loads the result; that step waits
// while the previous result is still held on the output. A new request is taken while the
// previous result still waits on the output. Positions are one-based; found position and
// count are reported in 5 bits.
// depends on olt_pkg, olt_cell, olt_ctrl and ordered_list_table_unit_assert.svh
`default_nettype none

`include "ordered_list_table_unit_assert.svh"

module ordered_list_table_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_kind,
    input  logic [4:0]          i_position,
    input  logic signed [31:0]  i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_ok,
    output logic signed [31:0]  o_data_out,
    output logic [4:0]          o_found_position,
    output logic [4:0]          o_entry_count,
    output logic                o_is_empty,
    output logic                o_is_full
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    olt_pkg::t_cell_cmd         w_cmd;
    logic [IDX_W-1:0]           w_target;
    logic [CNT_W-1:0]           w_count;
    logic [olt_pkg::DATA_W-1:0] w_entry [MAX_ENTRIES];
    olt_pkg::t_carry            w_carry [MAX_ENTRIES+1];
    logic [olt_pkg::DATA_W-1:0] w_data_out;

    assign w_carry[0] = '0;

    olt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ok             (o_ok),
        .o_data_out       (w_data_out),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_is_full        (o_is_full),
        .o_cmd            (w_cmd),
        .o_target         (w_target),
        .o_count          (w_count),
        .i_carry          (w_carry[MAX_ENTRIES])
    );

    assign o_data_out = w_data_out;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        // end cells see their own entry where a neighbor is missing
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == MAX_ENTRIES - 1) ? g : g + 1;

        olt_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .INDEX       (g),
            .CNT_W       (CNT_W),
            .IDX_W       (IDX_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_target      (w_target),
            .i_count       (w_count),
            .i_left_entry  (w_entry[LEFT]),
            .i_right_entry (w_entry[RIGHT]),
            .i_carry       (w_carry[g]),
            .o_entry       (w_entry[g]),
            .o_carry       (w_carry[g+1])
        );
    end

    `OLT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, w_count <= CNT_MAX, "entry count above capacity")
    `OLT_ASSERT_NEXT(a_update_has_result, i_clk, i_rst_n, w_cmd.op != olt_pkg::OP_HOLD, o_valid, "list changed without a result word")
    `OLT_ASSERT_IMPLY(a_idle_holds_list, i_clk, i_rst_n, !o_stall, w_cmd.op == olt_pkg::OP_HOLD, "list changed while idle")

endmodule

`default_nettype wire

@@ tb/olt_list_checker.sv @@
// checker for the ordered list table unit: follows the request and result channels,
// keeps its own copy of the list, and compares every result word with the expected one
// depends on olt_pkg for the request kinds and the failed-get word
`timescale 1ns / 1ps

module olt_list_checker #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  logic [2:0]         i_kind,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_value,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_stall,
    input  logic               i_ok,
    input  logic signed [31:0] i_data_out,
    input  logic [4:0]         i_found_position,
    input  logic [4:0]         i_entry_count,
    input  logic               i_is_empty,
    input  logic               i_is_full,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_held,
    output int                 o_checked
);

    typedef struct packed {
        logic               ok;
        logic signed [31:0] data_out;
        logic [4:0]         found_position;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } t_list_result;

    logic signed [31:0] list_words [MAX_ENTRIES];
    int                 list_len = 0;
    t_list_result       expected_q [$];
    t_list_result       want_word;
    t_list_result       got_word;
    int                 fail_count = 0;
    int                 checked = 0;

    // applies one request to the shadow list and returns the word it should produce
    function automatic t_list_result apply_request(logic [2:0] kind, logic [4:0] position,
                                                   logic signed [31:0] value);
        t_list_result r;
        int           p;
        int           j;
        logic         full;
        r    = '0;
        p    = int'(position);
        full = (list_len >= MAX_ENTRIES);
        case (kind)
            olt_pkg::KIND_APPEND: begin
                if (!full) begin
                    list_words[list_len] = value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            olt_pkg::KIND_INSERT: begin
                if (!full && p >= 1 && p <= list_len + 1) begin
                    for (j = list_len; j >= p; j--)
                        list_words[j] = list_words[j-1];
                    list_words[p-1] = value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            olt_pkg::KIND_DELETE: begin
                if (p >= 1 && p <= list_len) begin
                    r.data_out = list_words[p-1];
                    for (j = p; j < list_len; j++)
                        list_words[j-1] = list_words[j];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            olt_pkg::KIND_GET: begin
                if (p >= 1 && p <= list_len) begin
                    r.data_out = list_words[p-1];
                    r.ok       = 1'b1;
                end else begin
                    r.data_out = olt_pkg::FAIL_WORD;
                end
            end
            olt_pkg::KIND_LOCATE: begin
                // lowest matching position wins
                for (j = 0; j < list_len; j++) begin
                    if (!r.ok && list_words[j] == value) begin
                        r.found_position = 5'(j + 1);
                        r.ok             = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = 5'(list_len);
        r.is_empty    = (list_len == 0);
        r.is_full     = (list_len >= MAX_ENTRIES);
        return r;
    endfunction

    task automatic flag_failure(string why, logic have_want, t_list_result want,
                                t_list_result got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, why);
            if (have_want)
                $display("  expected ok=%0b data=%0d found=%0d count=%0d empty=%0b full=%0b",
                         want.ok, want.data_out, want.found_position, want.entry_count,
                         want.is_empty, want.is_full);
            $display("  actual   ok=%0b data=%0d found=%0d count=%0d empty=%0b full=%0b",
                     got.ok, got.data_out, got.found_position, got.entry_count,
                     got.is_empty, got.is_full);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall)
                expected_q.push_back(apply_request(i_kind, i_position, i_value));
            if (i_rsp_valid && !i_rsp_stall) begin
                got_word = '{i_ok, i_data_out, i_found_position, i_entry_count,
                             i_is_empty, i_is_full};
                if (expected_q.size() == 0) begin
                    flag_failure("result word with nothing expected", 1'b0, '0, got_word);
                end else begin
                    want_word = expected_q.pop_front();
                    checked++;
                    if (got_word.ok !== want_word.ok
                        || got_word.data_out !== want_word.data_out
                        || got_word.found_position !== want_word.found_position
                        || got_word.entry_count !== want_word.entry_count
                        || got_word.is_empty !== want_word.is_empty
                        || got_word.is_full !== want_word.is_full)
                        flag_failure("result word mismatch", 1'b1, want_word, got_word);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_q.size();
        o_held       <= list_len;
        o_checked    <= checked;
    end

endmodule

@@ tb/tb.sv @@
// top of the ordered list table unit testbench: clock, reset, request and result traffic
// with idling phases and a long output hold; verdict from olt_list_checker
// depends on olt_pkg, ordered_list_table_unit and olt_list_checker
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ENTRIES   = 16;
    localparam int PHASE_WORDS   = 125;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRESSURE_WORDS = 12;

    localparam logic [2:0]         KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]         KIND_UNUSED_MID   = 3'd6;
    localparam logic [2:0]         KIND_UNUSED_LAST  = 3'd7;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] WORD_NEG_ONE = -32'sd1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [2:0]         i_kind = '0;
    logic [4:0]         i_position = '0;
    logic signed [31:0] i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_ok;
    logic signed [31:0] o_data_out;
    logic [4:0]         o_found_position;
    logic [4:0]         o_entry_count;
    logic               o_is_empty;
    logic               o_is_full;

    int fail_count;
    int pending;
    int held;
    int checked;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent_words = 0;
    int unused_words = 0;
    bit growing = 1'b1;
    logic signed [31:0] value_pool [8];

    ordered_list_table_unit #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ok             (o_ok),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_is_full        (o_is_full)
    );

    olt_list_checker #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) checker_0 (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_value          (i_value),
        .i_rsp_valid      (o_valid),
        .i_rsp_stall      (i_stall),
        .i_ok             (o_ok),
        .i_data_out       (o_data_out),
        .i_found_position (o_found_position),
        .i_entry_count    (o_entry_count),
        .i_is_empty       (o_is_empty),
        .i_is_full        (o_is_full),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_held           (held),
        .o_checked        (checked)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stall, or a counted hold when the stimulus asks for one
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offers one request word, after a random idle gap, and waits until it is taken
    task automatic send_word(logic [2:0] kind, logic [4:0] position,
                             logic signed [31:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_position <= position;
        i_value    <= value;
        do @(posedge i_clk); while (o_stall);
        sent_words++;
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return value_pool[$urandom_range(7)];
        else if (r < 55)
            return ($urandom_range(1) != 0) ? WORD_MAX : WORD_MIN;
        return $urandom;
    endfunction

    // mostly well-formed traffic that fills the list up and drains it again
    task automatic send_random_word(output bit counted);
        logic [2:0]         kind;
        logic [4:0]         position;
        logic signed [31:0] value;
        int                 r;
        int                 len;
        len = held;
        if (len >= MAX_ENTRIES && $urandom_range(3) == 0)
            growing = 1'b0;
        if (len == 0)
            growing = 1'b1;
        r        = $urandom_range(99);
        value    = pick_value();
        position = 5'($urandom_range(31));
        if (r < 3) begin
            kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        end else if (r < 9) begin
            kind = 3'($urandom_range(olt_pkg::KIND_APPEND, olt_pkg::KIND_LOCATE));
        end else begin
            r = $urandom_range(99);
            if (growing)
                kind = (r < 30) ? olt_pkg::KIND_APPEND : (r < 55) ? olt_pkg::KIND_INSERT :
                       (r < 65) ? olt_pkg::KIND_DELETE :
                       (r < 80) ? olt_pkg::KIND_GET : olt_pkg::KIND_LOCATE;
            else
                kind = (r < 8) ? olt_pkg::KIND_APPEND : (r < 15) ? olt_pkg::KIND_INSERT :
                       (r < 60) ? olt_pkg::KIND_DELETE :
                       (r < 80) ? olt_pkg::KIND_GET : olt_pkg::KIND_LOCATE;
            if (kind == olt_pkg::KIND_INSERT)
                position = 5'($urandom_range(1, len + 1));
            else if (len == 0)
                position = 5'($urandom_range(0, 2));
            else
                position = 5'($urandom_range(1, len));
        end
        counted = (kind <= olt_pkg::KIND_LOCATE);
        if (!counted)
            unused_words++;
        send_word(kind, position, value);
    endtask

    task automatic run_phase(int sender_idle, int receiver_stall, bit with_hold);
        int n;
        bit counted;
        n = 0;
        idle_pct  = sender_idle;
        stall_pct <= receiver_stall;
        if (with_hold) begin
            // receiver holds off while words keep coming, so the block backs up
            hold_ask <= hold_ask + 1;
            idle_pct = 0;
            repeat (PRESSURE_WORDS) send_random_word(counted);
            idle_pct = sender_idle;
        end
        while (n < PHASE_WORDS) begin
            send_random_word(counted);
            if (counted)
                n++;
        end
    endtask

    initial begin
        value_pool[0] = WORD_MIN;
        value_pool[1] = WORD_MAX;
        value_pool[2] = WORD_NEG_ONE;
        value_pool[3] = '0;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extremes, bad positions, duplicates, unused kinds
        send_word(olt_pkg::KIND_GET,    5'd1,  '0);
        send_word(olt_pkg::KIND_DELETE, 5'd1,  '0);
        send_word(olt_pkg::KIND_LOCATE, 5'd0,  '0);
        send_word(olt_pkg::KIND_APPEND, 5'd0,  WORD_MIN);
        send_word(olt_pkg::KIND_APPEND, 5'd31, WORD_MAX);
        send_word(olt_pkg::KIND_INSERT, 5'd1,  WORD_NEG_ONE);
        send_word(olt_pkg::KIND_INSERT, 5'd4,  '0);
        send_word(olt_pkg::KIND_INSERT, 5'd6,  32'sd77);
        send_word(olt_pkg::KIND_INSERT, 5'd0,  32'sd78);
        send_word(olt_pkg::KIND_APPEND, 5'd0,  WORD_NEG_ONE);
        send_word(olt_pkg::KIND_LOCATE, 5'd0,  WORD_NEG_ONE);
        send_word(olt_pkg::KIND_LOCATE, 5'd0,  32'sd12345);
        send_word(olt_pkg::KIND_GET,    5'd0,  '0);
        send_word(olt_pkg::KIND_GET,    5'd5,  '0);
        send_word(olt_pkg::KIND_GET,    5'd6,  '0);
        send_word(olt_pkg::KIND_GET,    5'd31, WORD_MAX);
        send_word(olt_pkg::KIND_DELETE, 5'd0,  '0);
        send_word(olt_pkg::KIND_DELETE, 5'd6,  '0);
        send_word(olt_pkg::KIND_DELETE, 5'd5,  '0);
        send_word(olt_pkg::KIND_DELETE, 5'd1,  '0);
        send_word(olt_pkg::KIND_INSERT, 5'd31, WORD_MIN);
        send_word(KIND_UNUSED_FIRST, 5'd2, WORD_MAX);
        send_word(KIND_UNUSED_MID, 5'd31, WORD_MIN);
        send_word(KIND_UNUSED_LAST, 5'd1, WORD_NEG_ONE);
        unused_words += 3;

        run_phase(0, 0, 1'b1);
        run_phase(88, 0, 1'b0);
        run_phase(0, 88, 1'b0);
        run_phase(37, 37, 1'b0);

        i_valid <= 1'b0;
        stall_pct <= 0;
        while (pending != 0 || hold_left != 0)
            @(posedge i_clk);
        repeat (MAX_ENTRIES + 4) @(posedge i_clk);

        $display("run covered %0d request words (%0d of unused kinds), %0d results checked,",
                 sent_words, unused_words, checked);
        $display("four idling phases and a %0d-cycle output hold", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/olt_pkg.sv
rtl/core/olt_cell.sv
rtl/core/olt_ctrl.sv
rtl/core/ordered_list_table_unit.sv
tb/olt_list_checker.sv
tb/tb.sv
